### sv/per_slot_connection_acl_filter_macros.svh
// Assertion macros for the connection filter.
`ifndef PER_SLOT_CONNECTION_ACL_FILTER_MACROS_SVH
`define PER_SLOT_CONNECTION_ACL_FILTER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PSCAF_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define PSCAF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### sv/pscaf_pkg.sv
// Shared types and constants for the connection filter.
`default_nettype none
package pscaf_pkg;
    localparam logic [2:0] OP_CONNECT = 3'd0;
    localparam logic [2:0] OP_SET     = 3'd1;
    localparam logic [2:0] OP_GET     = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_STATUS  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [31:0] STATUS_MAGIC = 32'h4E457449;

    // Request fields as received.
    typedef struct packed {
        logic [15:0] rule_pos;
        logic [15:0] port;
        logic [31:0] dst_hash;
        logic [31:0] slot_id;
        logic        rule_wild;
        logic [2:0]  op;
    } req_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;       // capture request
        logic clr_scan;   // reset scan index and flags
        logic slot_step;  // examine slot at scan index
        logic rule_step;  // examine rule at scan index
        logic take_slot;  // allocate free slot
        logic commit;     // apply op and build result
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic slot_last;
        logic rule_last;
        logic found;
        logic allowed;
    } sts_t;
endpackage
`default_nettype wire

### sv/pscaf_ctrl.sv
// Controller state machine sequencing slot and rule scans.
`default_nettype none
module pscaf_ctrl
    import pscaf_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        req_valid,
    output logic       req_ready,
    input  wire  [2:0] req_op,
    input  wire        res_free,
    output logic       res_load,
    output cmd_t       cmd,
    input  sts_t       sts
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SLOT  = 3'd1;
    localparam logic [2:0] S_RULE  = 3'd2;
    localparam logic [2:0] S_TAKE  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        req_ready = 1'b0;
        res_load = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    cmd.load = 1'b1;
                    cmd.clr_scan = 1'b1;
                    state_next = S_SLOT;
                end
            end
            S_SLOT: begin
                cmd.slot_step = 1'b1;
                if (sts.slot_last) begin
                    cmd.clr_scan = 1'b1;
                    if (req_op == OP_CONNECT || req_op == OP_GET) state_next = S_RULE;
                    else if (req_op == OP_SET) state_next = S_TAKE;
                    else state_next = S_DONE;
                end
            end
            S_RULE: begin
                cmd.rule_step = 1'b1;
                if (sts.rule_last) state_next = S_DONE;
            end
            S_TAKE: begin
                cmd.take_slot = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_free) begin
                    cmd.commit = 1'b1;
                    res_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### sv/pscaf_dp.sv
// Datapath: slot table, rule memory, counters and result build.
`default_nettype none
module pscaf_dp
    import pscaf_pkg::*;
#(
    parameter int SLOTS = 8,
    parameter int RULES = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  req_t        req_in,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic [2:0]  cur_op,
    output logic [1:0]  o_status_code,
    output logic        o_allowed_or_ok,
    output logic        o_deny_event,
    output logic [4:0]  o_active_rules,
    output logic [31:0] o_slot_denials,
    output logic [31:0] o_slot_connections,
    output logic        o_slot_is_active,
    output logic [3:0]  o_active_slots,
    output logic [31:0] o_all_denials,
    output logic [31:0] o_all_connections,
    output logic [31:0] o_magic_word
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RW = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int KW = SW + RW;
    // Each slot owns a power-of-two block of rule entries
    localparam int RP = 1 << RW;
    localparam int NR = SLOTS * RP;
    localparam int CW = $clog2(RULES + 1);
    localparam int AW = $clog2(SLOTS + 1);

    req_t req_reg;
    logic [31:0] ident_reg [SLOTS];
    logic [SLOTS-1:0] sv_reg;
    logic [31:0] sden_reg [SLOTS];
    logic [31:0] scon_reg [SLOTS];
    logic [NR-1:0] rv_reg;
    logic [31:0] rhash_mem [NR];
    logic [15:0] rport_mem [NR];
    logic        rwild_mem [NR];
    logic [AW-1:0] act_reg;
    logic [31:0] den_reg, con_reg;

    logic [SW-1:0] sidx_reg;
    logic [RW-1:0] ridx_reg;
    logic [SW-1:0] hit_reg, free_reg;
    logic found_reg, free_ok_reg, allow_reg, rd_pend_reg, last_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0] rd_hash_reg;
    logic [15:0] rd_port_reg;
    logic rd_wild_reg, rd_valid_reg;

    logic bad_idx;
    logic [KW-1:0] rd_addr, wr_addr;
    logic [SW-1:0] tgt;

    assign cur_op = req_reg.op;
    assign bad_idx = ({16'd0, req_reg.rule_pos} >= 32'(RULES));
    assign rd_addr = {hit_reg, ridx_reg};
    assign tgt = found_reg ? hit_reg : free_reg;
    assign wr_addr = {tgt, req_reg.rule_pos[RW-1:0]};

    assign sts.slot_last = (sidx_reg == SW'(SLOTS - 1));
    assign sts.rule_last = last_reg && !rd_pend_reg;
    assign sts.found = found_reg;
    assign sts.allowed = allow_reg;

    // Rule memory: one read a cycle, registered
    always_ff @(posedge aclk) begin
        rd_hash_reg <= rhash_mem[rd_addr];
        rd_port_reg <= rport_mem[rd_addr];
        rd_wild_reg <= rwild_mem[rd_addr];
        if (cmd.commit && req_reg.op == OP_SET && !bad_idx && (found_reg || free_ok_reg)) begin
            rhash_mem[wr_addr] <= req_reg.dst_hash;
            rport_mem[wr_addr] <= req_reg.port;
            rwild_mem[wr_addr] <= req_reg.rule_wild;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) req_reg <= req_in;
        rd_valid_reg <= rv_reg[rd_addr];
    end

    // Scan and table state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg <= '0; rv_reg <= '0; act_reg <= '0; den_reg <= '0; con_reg <= '0;
            sidx_reg <= '0; ridx_reg <= '0; found_reg <= 1'b0; free_ok_reg <= 1'b0;
            allow_reg <= 1'b0; rd_pend_reg <= 1'b0; last_reg <= 1'b0; cnt_reg <= '0;
            hit_reg <= '0; free_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                ident_reg[i] <= '0; sden_reg[i] <= '0; scon_reg[i] <= '0;
            end
        end else begin
            if (cmd.clr_scan) begin
                sidx_reg <= '0; ridx_reg <= '0; rd_pend_reg <= 1'b0; last_reg <= 1'b0;
                allow_reg <= 1'b0; cnt_reg <= '0;
            end
            if (cmd.load) begin
                found_reg <= 1'b0; free_ok_reg <= 1'b0;
            end
            // Slot walk: first matching, first free
            if (cmd.slot_step) begin
                if (!sts.slot_last) sidx_reg <= sidx_reg + 1'b1;
                if (sv_reg[sidx_reg] && ident_reg[sidx_reg] == req_reg.slot_id && !found_reg) begin
                    found_reg <= 1'b1; hit_reg <= sidx_reg;
                end
                if (!sv_reg[sidx_reg] && !free_ok_reg) begin
                    free_ok_reg <= 1'b1; free_reg <= sidx_reg;
                end
            end
            // Rule walk: read issued, evaluated next cycle
            if (cmd.rule_step) begin
                if (!last_reg) begin
                    if (ridx_reg == RW'(RULES - 1)) last_reg <= 1'b1;
                    else ridx_reg <= ridx_reg + 1'b1;
                end
                rd_pend_reg <= !last_reg;
                if (rd_pend_reg && rd_valid_reg && found_reg) begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if ((rd_port_reg == 16'd0 || rd_port_reg == req_reg.port) &&
                        (rd_wild_reg || rd_hash_reg == req_reg.dst_hash))
                        allow_reg <= 1'b1;
                end
            end
            // Allocate a slot for set
            if (cmd.take_slot && !bad_idx && !found_reg && free_ok_reg) begin
                ident_reg[free_reg] <= req_reg.slot_id;
                sv_reg[free_reg] <= 1'b1;
                sden_reg[free_reg] <= '0; scon_reg[free_reg] <= '0;
                rv_reg[free_reg*RP +: RULES] <= '0;
                act_reg <= act_reg + 1'b1;
            end
            // Apply op
            if (cmd.commit) begin
                case (req_reg.op)
                    OP_CONNECT: begin
                        if (allow_reg) begin
                            scon_reg[hit_reg] <= scon_reg[hit_reg] + 1'b1;
                            con_reg <= con_reg + 1'b1;
                        end else begin
                            if (found_reg) sden_reg[hit_reg] <= sden_reg[hit_reg] + 1'b1;
                            den_reg <= den_reg + 1'b1;
                        end
                    end
                    OP_SET: if (!bad_idx && (found_reg || free_ok_reg))
                        rv_reg[wr_addr] <= 1'b1;
                    OP_CLEAR: if (found_reg) begin
                        rv_reg[hit_reg*RP +: RULES] <= '0;
                        sv_reg[hit_reg] <= 1'b0;
                        sden_reg[hit_reg] <= '0; scon_reg[hit_reg] <= '0;
                        if (act_reg != '0) act_reg <= act_reg - 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Result fields
    always_comb begin
        o_status_code = ST_OK; o_allowed_or_ok = 1'b0; o_deny_event = 1'b0;
        o_active_rules = '0; o_slot_denials = '0; o_slot_connections = '0;
        o_slot_is_active = 1'b0; o_active_slots = '0; o_all_denials = '0;
        o_all_connections = '0; o_magic_word = '0;
        case (req_reg.op)
            OP_CONNECT: begin
                o_allowed_or_ok = allow_reg; o_deny_event = !allow_reg;
            end
            OP_SET: begin
                if (bad_idx) o_status_code = ST_BAD_INDEX;
                else if (!found_reg && !free_ok_reg) o_status_code = ST_FULL;
                else o_allowed_or_ok = 1'b1;
            end
            OP_GET: if (found_reg) begin
                o_active_rules = 5'(cnt_reg);
                o_slot_denials = sden_reg[hit_reg];
                o_slot_connections = scon_reg[hit_reg];
                o_slot_is_active = 1'b1;
            end
            OP_CLEAR: o_allowed_or_ok = 1'b1;
            OP_STATUS: begin
                o_active_slots = 4'(act_reg);
                o_all_denials = den_reg; o_all_connections = con_reg;
                o_magic_word = STATUS_MAGIC;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### sv/per_slot_connection_acl_filter.sv
// Each request walks every slot; connect and get then walk the rules, set then
// allocates a slot, and clear, status and unused codes go straight to the result.
// One request is in flight; the result loads once the output register is free, and the
// next request is accepted in the cycle after. The rule walk reads one rule a cycle.
// Reset (aresetn low, synchronous) empties the slot table, rule valid bits and counters.
// Top level: streaming wrapper joining controller and datapath.
`default_nettype none
`include "per_slot_connection_acl_filter_macros.svh"
module per_slot_connection_acl_filter
    import pscaf_pkg::*;
#(
    parameter int SLOTS = 8,
    parameter int RULES = 16
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // op[2:0], slot_id[34:3], dst_hash[66:35], port[82:67], rule_pos[98:83], pad
    input  wire  [103:0] s_tdata,
    // rule_wild
    input  wire          s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // status_code[1:0], allowed_or_ok[2], deny_event[3], active_rules[8:4],
    // slot_denials[40:9], slot_connections[72:41], slot_is_active[73],
    // active_slots[77:74], all_denials[109:78], all_connections[141:110],
    // magic_word[173:142], pad
    output logic [175:0] m_tdata
);
    req_t req_in;
    cmd_t cmd;
    sts_t sts;
    logic [2:0] cur_op;
    logic res_load;
    logic [1:0] f_sc; logic f_ok, f_aud, f_act; logic [4:0] f_rc;
    logic [31:0] f_sd, f_scn, f_ad, f_ac, f_mw; logic [3:0] f_as;
    logic [175:0] res_reg;
    logic mv_reg;

    assign req_in.op = s_tdata[2:0];
    assign req_in.slot_id = s_tdata[34:3];
    assign req_in.dst_hash = s_tdata[66:35];
    assign req_in.port = s_tdata[82:67];
    assign req_in.rule_pos = s_tdata[98:83];
    assign req_in.rule_wild = s_tuser;

    pscaf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .req_valid(s_tvalid), .req_ready(s_tready),
        .req_op(cur_op), .res_free(!mv_reg || m_tready), .res_load(res_load),
        .cmd(cmd), .sts(sts)
    );

    pscaf_dp #(.SLOTS(SLOTS), .RULES(RULES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .req_in(req_in), .cmd(cmd), .sts(sts),
        .cur_op(cur_op), .o_status_code(f_sc), .o_allowed_or_ok(f_ok),
        .o_deny_event(f_aud), .o_active_rules(f_rc), .o_slot_denials(f_sd),
        .o_slot_connections(f_scn), .o_slot_is_active(f_act), .o_active_slots(f_as),
        .o_all_denials(f_ad), .o_all_connections(f_ac), .o_magic_word(f_mw)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) mv_reg <= 1'b0;
        else if (res_load) mv_reg <= 1'b1;
        else if (m_tready) mv_reg <= 1'b0;
        if (res_load)
            res_reg <= {2'b00, f_mw, f_ac, f_ad, f_as, f_act, f_scn, f_sd, f_rc,
                        f_aud, f_ok, f_sc};
    end

    assign m_tvalid = mv_reg;
    assign m_tdata = res_reg;

    `PSCAF_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, res_load, !mv_reg || m_tready,
        "result overwritten while stalled")
    `PSCAF_ASSERT_NEXT(a_load_valid, aclk, aresetn, res_load, m_tvalid,
        "result not presented after load")
    `PSCAF_ASSERT_IMPL(a_one_cmd, aclk, aresetn, 1'b1,
        $onehot0({cmd.slot_step, cmd.rule_step, cmd.take_slot, cmd.commit}),
        "conflicting datapath commands")
endmodule
`default_nettype wire
